/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL, removable with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* sv/bdpc_pkg.sv */
// ---------------------------------------------------------------------------
// bdpc_pkg
// Types and constants of the button debounce and press classifier.
// ---------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 10;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOME     = 2'd2;

  localparam logic [DebounceW-1:0] DEBOUNCE_RESET = 10'd35;
  localparam logic [HoldW-1:0]     LONG_RESET     = 16'd700;
  localparam logic [HoldW-1:0]     HOME_RESET     = 16'd2000;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             raw_pressed;
  } in_item_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic home_press;
    logic activity;
    logic stable_level;
  } out_item_t;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ms;
    logic [HoldW-1:0]     long_press_ms;
    logic [HoldW-1:0]     home_press_ms;
  } cfg_t;

  typedef struct packed {
    logic             last_raw_level;
    logic             stable_pressed;
    logic             long_done;
    logic             home_done;
    logic [TimeW-1:0] last_change_time;
    logic [TimeW-1:0] press_start_time;
  } state_t;

endpackage

/* sv/bdpc_step.sv */
// ---------------------------------------------------------------------------
// bdpc_step
// One poll of the debounce and press classification, purely combinational.
// ---------------------------------------------------------------------------
module bdpc_step (
  input  bdpc_pkg::cfg_t     cfg,
  input  bdpc_pkg::state_t   st,
  input  bdpc_pkg::in_item_t item,
  output bdpc_pkg::state_t   st_nxt,
  output bdpc_pkg::out_item_t res
);
  import bdpc_pkg::*;

  always_comb begin
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] since_change;
    st_nxt = st;
    res    = '0;

    if (item.raw_pressed != st.last_raw_level) begin
      st_nxt.last_raw_level   = item.raw_pressed;
      st_nxt.last_change_time = item.now_ms;
    end

    // Hold time while stably pressed; long and home fire at most once each.
    held = item.now_ms - st.press_start_time;
    if (item.raw_pressed && st.stable_pressed) begin
      if (!st.long_done && held >= {{(TimeW-HoldW){1'b0}}, cfg.long_press_ms}) begin
        st_nxt.long_done = 1'b1;
        res.long_press   = 1'b1;
      end else if (st.long_done && !st.home_done &&
                   held >= {{(TimeW-HoldW){1'b0}}, cfg.home_press_ms}) begin
        st_nxt.home_done = 1'b1;
        res.home_press   = 1'b1;
      end
    end

    // The raw level is accepted once it has held for the debounce time.
    since_change = item.now_ms - st_nxt.last_change_time;
    if (since_change >= {{(TimeW-DebounceW){1'b0}}, cfg.debounce_ms} &&
        item.raw_pressed != st.stable_pressed) begin
      st_nxt.stable_pressed = item.raw_pressed;
      if (item.raw_pressed) begin
        res.activity            = 1'b1;
        st_nxt.press_start_time = item.now_ms;
      end else begin
        st_nxt.press_start_time = '0;
        res.short_press         = !st.long_done;
      end
      st_nxt.long_done = 1'b0;
      st_nxt.home_done = 1'b0;
    end

    res.stable_level = st_nxt.stable_pressed;
  end

endmodule

/* sv/button_debounce_press_classifier.sv */
// ---------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces polled button samples and classifies short, long and home presses.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake           Payload              Direction
//   in       in_valid/in_stall   in_item (poll)       into block
//   out      out_valid/out_stall out_item (events)    out of block
//   cfg      cfg_we              cfg_index/cfg_wdata  into block
//
// Every poll gives exactly one result. The poll sits in the input register
// while the classification runs, and the result is written to the output
// register as the poll leaves the input register. A new poll can be taken in
// every cycle unless a stall on the output holds it up. Reset is synchronous
// and restores the default thresholds and a released button. A stall on the
// output holds the output register and, once the input register is also
// full, stalls the input.
//
`include "assert_macros.svh"

module button_debounce_press_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bdpc_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bdpc_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [bdpc_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bdpc_pkg::CfgDataW-1:0]       cfg_wdata
);
  import bdpc_pkg::*;

  // Input register stage.
  logic      a_valid_r;
  in_item_t  a_item_r;

  // Output register stage.
  logic      out_valid_r;
  out_item_t out_item_r;

  // Configuration and classification state.
  cfg_t      cfg_r, cfg_nxt;
  state_t    st_r;
  state_t    st_nxt;
  out_item_t res;

  logic      out_free;
  logic      xfer;

  // Event pulses of the pending result, short press in the top bit.
  logic [3:0] out_pulses;
  logic       out_level_bad;

  // The output register can take a result when it is empty or being read.
  assign out_free = !out_valid_r || !out_stall;
  // A poll moves from the input register through the classifier.
  assign xfer     = a_valid_r && out_free;
  // The input register accepts when it is empty or emptying this cycle.
  assign in_stall = a_valid_r && !out_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  bdpc_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (a_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Register write decode; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_nxt.debounce_ms   = cfg_wdata[DebounceW-1:0];
        CFG_LONG:     cfg_nxt.long_press_ms = cfg_wdata[HoldW-1:0];
        CFG_HOME:     cfg_nxt.home_press_ms = cfg_wdata[HoldW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{debounce_ms:   DEBOUNCE_RESET,
                       long_press_ms: LONG_RESET,
                       home_press_ms: HOME_RESET};
      st_r        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      if (in_valid && !in_stall) begin
        a_valid_r <= 1'b1;
      end else if (xfer) begin
        a_valid_r <= 1'b0;
      end
      if (xfer) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_item_r <= in_item;
    end
    if (xfer) begin
      out_item_r <= res;
    end
  end

  assign out_pulses = {out_item_r.short_press, out_item_r.long_press,
                       out_item_r.home_press, out_item_r.activity};
  // A short press needs a released level; the other events a pressed one.
  assign out_level_bad = out_item_r.stable_level ? out_pulses[3] : |out_pulses[2:0];

  // At most one event pulse per poll.
  `ASSERT_CLK(a_one_event, clk, rst_n, out_valid_r |-> $countones(out_pulses) <= 1)
  // Press events come with a pressed level, a short press with a released one.
  `ASSERT_NEVER(a_level_events, clk, rst_n, out_valid_r && out_level_bad)
  // The pending result always reflects the current debounced level.
  `ASSERT_CLK(a_level_state, clk, rst_n, out_valid_r |-> out_item_r.stable_level == st_r.stable_pressed)
  // A home pulse only ever follows a long press in the same hold.
  `ASSERT_CLK(a_home_after_long, clk, rst_n, (out_valid_r && out_pulses[1]) |-> st_r.long_done)

endmodule

/* tb/button_debounce_press_classifier_tb.sv */
// ---------------------------------------------------------------------------
// button_debounce_press_classifier_tb
// Self-checking testbench for the button debounce and press classifier.
// A queue of polls feeds a bursty driver. A monitor that stalls on its own
// pattern compares every event item with a cycle-free predictor of the
// debounce and press classification, field by field, in arrival order.
// ---------------------------------------------------------------------------
module button_debounce_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdpc_pkg::*;

  // Index 3 is not a register. A write to it must leave every threshold alone.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // Cycles without any accepted item before the run is declared hung. The
  // longest quiet spell in a correct run is a receiver stall run, a sender
  // gap or a handful of register writes.
  localparam int unsigned HANG_LIMIT = 5000;

  // Mismatch lines stop after this many so that a broken block cannot flood
  // the log. Every mismatch is still counted.
  localparam int unsigned MAX_REPORTS = 40;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_DEBOUNCE;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Polls waiting for the driver, and event items the block owes us.
  in_item_t  poll_queue[$];
  out_item_t expected_events[$];

  // Predictor copy of the thresholds and of the button state.
  cfg_t   thr_cfg = '{DEBOUNCE_RESET, LONG_RESET, HOME_RESET};
  state_t btn_st = '0;

  int unsigned err_count = 0;
  int unsigned result_count = 0;
  int unsigned idle_cycles = 0;

  button_debounce_press_classifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Advances the predicted button state by one poll and returns the events
  // that the poll raises. The raw-change timestamp is updated first, so a
  // zero debounce accepts a change in the same poll. The long and home checks
  // are exclusive, which delays a home threshold below the long one by a poll.
  function automatic out_item_t classify_poll(in_item_t poll);
    out_item_t        ev;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] since_change;
    ev = '0;
    if (poll.raw_pressed != btn_st.last_raw_level) begin
      btn_st.last_raw_level   = poll.raw_pressed;
      btn_st.last_change_time = poll.now_ms;
    end
    if (poll.raw_pressed && btn_st.stable_pressed) begin
      // Unsigned and modulo 2^32, so time running backwards looks like a very
      // long hold.
      held = poll.now_ms - btn_st.press_start_time;
      if (!btn_st.long_done && held >= TimeW'(thr_cfg.long_press_ms)) begin
        btn_st.long_done = 1'b1;
        ev.long_press    = 1'b1;
      end else if (btn_st.long_done && !btn_st.home_done &&
                   held >= TimeW'(thr_cfg.home_press_ms)) begin
        btn_st.home_done = 1'b1;
        ev.home_press    = 1'b1;
      end
    end
    since_change = poll.now_ms - btn_st.last_change_time;
    if (since_change >= TimeW'(thr_cfg.debounce_ms) &&
        poll.raw_pressed != btn_st.stable_pressed) begin
      btn_st.stable_pressed = poll.raw_pressed;
      if (poll.raw_pressed) begin
        ev.activity             = 1'b1;
        btn_st.press_start_time = poll.now_ms;
      end else begin
        btn_st.press_start_time = '0;
        ev.short_press          = !btn_st.long_done;
      end
      btn_st.long_done = 1'b0;
      btn_st.home_done = 1'b0;
    end
    ev.stable_level = btn_st.stable_pressed;
    return ev;
  endfunction

  task automatic report_mismatch(string what, logic exp_bit, logic got_bit);
    if (err_count < MAX_REPORTS) begin
      $display("MISMATCH event item %0d: %s expected %0b, got %0b",
               result_count, what, exp_bit, got_bit);
    end
    err_count++;
  endtask

  task automatic check_field(string what, logic exp_bit, logic got_bit);
    if (exp_bit !== got_bit) begin
      report_mismatch(what, exp_bit, got_bit);
    end
  endtask

  task automatic add_poll(logic [TimeW-1:0] t, logic raw);
    in_item_t p;
    p.now_ms      = t;
    p.raw_pressed = raw;
    poll_queue.push_back(p);
  endtask

  // Register writes happen only with the block drained, so the predictor can
  // take the new value at once. Only the low bits of the data are kept.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: thr_cfg.debounce_ms   = data[DebounceW-1:0];
      CFG_LONG:     thr_cfg.long_press_ms = data[HoldW-1:0];
      CFG_HOME:     thr_cfg.home_press_ms = data[HoldW-1:0];
      default: ;
    endcase
  endtask

  // Sampled on the falling edge, when every update of the rising edge has
  // settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (poll_queue.size() != 0 || in_valid || expected_events.size() != 0);
  endtask

  // Random polls, mostly whole press episodes: some bounce, a stable hold of
  // random length, bounce again and a release. Time steps scale with the
  // largest threshold so that long and home events are reached. The rest is
  // noise with jumps backwards and far forwards in time.
  task automatic run_random(int unsigned n_polls);
    int unsigned      made;
    int unsigned      unit;
    int unsigned      db;
    logic [TimeW-1:0] cur_t;
    made  = 0;
    cur_t = $urandom();
    db    = thr_cfg.debounce_ms;
    unit  = db;
    if (thr_cfg.long_press_ms > unit) unit = thr_cfg.long_press_ms;
    if (thr_cfg.home_press_ms > unit) unit = thr_cfg.home_press_ms;
    unit = unit / 4 + 1;
    while (made < n_polls) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 4)) begin
          cur_t += $urandom_range(0, db / 2 + 1);
          add_poll(cur_t, 1'($urandom_range(0, 1)));
          made++;
        end
        repeat ($urandom_range(1, 16)) begin
          cur_t += $urandom_range(0, unit);
          add_poll(cur_t, 1'b1);
          made++;
        end
        repeat ($urandom_range(0, 3)) begin
          cur_t += $urandom_range(0, db / 2 + 1);
          add_poll(cur_t, 1'($urandom_range(0, 1)));
          made++;
        end
        repeat ($urandom_range(1, 4)) begin
          cur_t += $urandom_range(0, 2 * db + 2);
          add_poll(cur_t, 1'b0);
          made++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       cur_t -= $urandom_range(0, unit);
            1:       cur_t += $urandom();
            default: cur_t += $urandom_range(0, unit);
          endcase
          add_poll(cur_t, 1'($urandom_range(0, 1)));
          made++;
        end
      end
    end
    wait_idle();
  endtask

  // Driver. The sender runs in bursts of random length separated by random
  // gaps. A gap of zero gives long stretches of back-to-back polls. Each
  // accepted poll is run through the predictor right away.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_events.push_back(classify_poll(in_item));
      end
      // A held poll stays put until taken. Otherwise the next one is chosen.
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (poll_queue.size() != 0) begin
          in_item  <= poll_queue.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. The receiver switches among no stalls, random stalls, a fixed
  // stall pattern and heavy stalls, each for a stretch of random length.
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk) begin
    out_item_t exp_ev;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          if (err_count < MAX_REPORTS) begin
            $display("MISMATCH event item %0d arrived with no poll pending",
                     result_count);
          end
          err_count++;
        end else begin
          exp_ev = expected_events.pop_front();
          check_field("short_press", exp_ev.short_press, out_item.short_press);
          check_field("long_press", exp_ev.long_press, out_item.long_press);
          check_field("home_press", exp_ev.home_press, out_item.home_press);
          check_field("activity", exp_ev.activity, out_item.activity);
          check_field("stable_level", exp_ev.stable_level, out_item.stable_level);
        end
        result_count++;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("button_debounce_press_classifier regression: fail");
        $finish;
      end
    end
  end

  initial begin
    // Directed polls under the reset thresholds (35, 700, 2000 ms). They walk
    // through a press that reaches long and then home, a bounce during the
    // hold, a release after a long press and a clean short press. They end
    // with a press across the 32-bit wrap, time running backwards and the
    // largest timestamp.
    add_poll(32'd0, 1'b0);
    add_poll(32'd10, 1'b1);
    add_poll(32'd20, 1'b1);
    add_poll(32'd45, 1'b1);
    add_poll(32'd744, 1'b1);
    add_poll(32'd745, 1'b1);
    add_poll(32'd2044, 1'b1);
    add_poll(32'd2045, 1'b1);
    add_poll(32'd5000, 1'b1);
    add_poll(32'd5010, 1'b0);
    add_poll(32'd5030, 1'b1);
    add_poll(32'd5040, 1'b0);
    add_poll(32'd5075, 1'b0);
    add_poll(32'd5080, 1'b1);
    add_poll(32'd5115, 1'b1);
    add_poll(32'd5120, 1'b0);
    add_poll(32'd5155, 1'b0);
    add_poll(32'hFFFF_FFF0, 1'b1);
    add_poll(32'h0000_0013, 1'b1);
    add_poll(32'h0000_0010, 1'b1);
    add_poll(32'h0000_0011, 1'b1);
    add_poll(32'hFFFF_FFFF, 1'b0);
    add_poll(32'h0000_0022, 1'b0);
    add_poll(32'h7FFF_FFFF, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // All thresholds at zero: changes are accepted in the same poll and the
    // home event follows the long event one poll later.
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_LONG, 16'd0);
    write_reg(CFG_HOME, 16'd0);
    run_random(150);

    // All thresholds at their maximum. The debounce data carries ones above
    // its ten bits, which must be dropped.
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_LONG, 16'hFFFF);
    write_reg(CFG_HOME, 16'hFFFF);
    run_random(150);

    // Home threshold below the long threshold.
    write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 20)));
    write_reg(CFG_LONG, 16'd500);
    write_reg(CFG_HOME, 16'd50);
    run_random(150);

    // A write to the unused index must change nothing.
    write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    run_random(100);

    // Random thresholds, half of them small, so that events come often.
    repeat (5) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 60)));
        write_reg(CFG_LONG, 16'($urandom_range(0, 1500)));
        write_reg(CFG_HOME, 16'($urandom_range(0, 3000)));
      end else begin
        write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 65535)));
        write_reg(CFG_LONG, 16'($urandom_range(0, 65535)));
        write_reg(CFG_HOME, 16'($urandom_range(0, 65535)));
      end
      run_random(200);
    end

    // A short drain lets any stray extra event item show up.
    repeat (6) @(posedge clk);
    if (err_count == 0) begin
      $display("button_debounce_press_classifier regression: pass");
    end else begin
      $display("button_debounce_press_classifier regression: fail");
    end
    $finish;
  end

endmodule
